// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl, used by pixel_art_upscale_2x_3x
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off during reset
`define ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold at a rising edge, off during reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/pau_pkg.sv -----
// shared types and constants for the pixel-art upscaler
// used by pau_rules and pixel_art_upscale_2x_3x, depends on nothing
package pau_pkg;

    localparam int PIX_BITS    = 32;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_BITS  = 12;
    localparam int HEIGHT_BITS = 13;
    localparam int SCALE_BITS  = 2;
    localparam int CFG_BITS    = 13;
    localparam int CFG_IDX_BITS = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE  = 2'd2;

    // register reset values
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 2'd2;
    localparam logic [SCALE_BITS-1:0]  SCALE_3X     = 2'd3;

    typedef logic [PIX_BITS-1:0] pix_t;
    // one window column: slot 0 row y-2, slot 1 row y-1, slot 2 row y
    typedef pix_t [2:0] col3_t;
    // nine pixels of a 3x3 neighborhood or of an output block, raster order
    typedef pix_t [8:0] blk_t;

endpackage

// ----- hw/rtl/pau_rules.sv -----
// scale2x / scale3x pixel rules for one 3x3 neighborhood
// depends on pau_pkg
module pau_rules (
    input  logic           three,
    input  pau_pkg::blk_t  nbr,
    output pau_pkg::blk_t  blk
);

    pau_pkg::pix_t a, b, c, d, e, f, g, h, i;
    logic tl, tr, bl, br;

    // neighborhood names, A..I in raster order
    always_comb
    begin
        a = nbr[0];
        b = nbr[1];
        c = nbr[2];
        d = nbr[3];
        e = nbr[4];
        f = nbr[5];
        g = nbr[6];
        h = nbr[7];
        i = nbr[8];
    end

    // corner conditions shared by both modes
    assign tl = (d == b) && (d != h) && (b != f);
    assign tr = (b == f) && (b != d) && (f != h);
    assign bl = (h == d) && (h != f) && (d != b);
    assign br = (f == h) && (f != b) && (h != d);

    // block pixels
    always_comb
    begin
        blk = '0;
        if (!three)
        begin
            blk[0] = tl ? b : e;
            blk[1] = tr ? f : e;
            blk[3] = bl ? d : e;
            blk[4] = br ? h : e;
        end
        else
        begin
            blk[0] = tl ? d : e;
            blk[1] = ((tl && (e != c)) || (tr && (e != a))) ? b : e;
            blk[2] = tr ? f : e;
            blk[3] = ((bl && (e != a)) || (tl && (e != g))) ? d : e;
            blk[4] = e;
            blk[5] = ((tr && (e != i)) || (br && (e != c))) ? f : e;
            blk[6] = bl ? d : e;
            blk[7] = ((br && (e != g)) || (bl && (e != i))) ? h : e;
            blk[8] = br ? f : e;
        end
    end

endmodule

// ----- hw/rtl/pixel_art_upscale_2x_3x.sv -----
// pixel-art upscaler top level: line store, 3x3 window, block sequencer
// depends on pau_pkg, pau_rules and assert_macros.svh
//
// usage:
//   source pixels enter in raster order on pixel / in_valid / in_stall; each
//   accepted word yields zero to four blocks on out_0..out_8 with block_col,
//   block_row and last, handed over on out_valid / out_stall. a block leaves
//   one row and one column after its center pixel; the last row and the last
//   column are flushed by the pixels that close them.
//   a block passes from the window stage through the block sequencer into
//   the output register after the pixel that completes it is accepted.
//   throughput: one pixel per cycle while each pixel gives at most one block
//   and out_stall is low; a pixel that gives more holds in_stall while the
//   sequencer hands one block per cycle to the output register unless stalled.
//   the line store is one 2048 x 64 memory, read and written once per pixel;
//   a same-address write and read in one cycle is forwarded.
//   reset clears the counters, the window and all valid flags; the line store
//   holds no reset and needs no clearing pass. image_width, image_height and
//   scale come from the cfg port; the user must write them only while idle;
//   the block does not enforce it. when out_stall is high the output register
//   holds, the sequencer and the window stage fill up, and in_stall rises.
`include "assert_macros.svh"

module pixel_art_upscale_2x_3x (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [pau_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pau_pkg::CFG_BITS-1:0]         cfg_data,
    // source pixels
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pau_pkg::PIX_BITS-1:0]         pixel,
    // output blocks
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pau_pkg::COL_BITS-1:0]         block_col,
    output logic [pau_pkg::ROW_BITS-1:0]         block_row,
    output logic [pau_pkg::PIX_BITS-1:0]         out_0,
    output logic [pau_pkg::PIX_BITS-1:0]         out_1,
    output logic [pau_pkg::PIX_BITS-1:0]         out_2,
    output logic [pau_pkg::PIX_BITS-1:0]         out_3,
    output logic [pau_pkg::PIX_BITS-1:0]         out_4,
    output logic [pau_pkg::PIX_BITS-1:0]         out_5,
    output logic [pau_pkg::PIX_BITS-1:0]         out_6,
    output logic [pau_pkg::PIX_BITS-1:0]         out_7,
    output logic [pau_pkg::PIX_BITS-1:0]         out_8,
    output logic                                 last
);

    localparam int PB = pau_pkg::PIX_BITS;
    localparam int CB = pau_pkg::COL_BITS;
    localparam int RB = pau_pkg::ROW_BITS;

    // row slots of a window column
    localparam logic [1:0] SLOT_OLDER = 2'd0;
    localparam logic [1:0] SLOT_NEWER = 2'd1;
    localparam logic [1:0] SLOT_CUR   = 2'd2;

    // emission codes, in output order
    localparam logic [1:0] EM_PREV_LEFT = 2'd0;
    localparam logic [1:0] EM_PREV_END  = 2'd1;
    localparam logic [1:0] EM_LAST_LEFT = 2'd2;
    localparam logic [1:0] EM_LAST_END  = 2'd3;

    function automatic pau_pkg::pix_t pick_slot(pau_pkg::col3_t c, logic [1:0] s);
        pau_pkg::pix_t r;
        case (s)
            SLOT_OLDER: r = c[0];
            SLOT_NEWER: r = c[1];
            default:    r = c[2];
        endcase
        return r;
    endfunction

    // configuration registers
    logic [pau_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [pau_pkg::HEIGHT_BITS-1:0] height_reg;
    logic [pau_pkg::SCALE_BITS-1:0]  scale_reg;

    // position of the next pixel
    logic [CB-1:0] col_reg;
    logic [RB-1:0] row_reg;

    // line store: [2*PB-1:PB] row y-2, [PB-1:0] row y-1
    logic [2*PB-1:0] line_mem [pau_pkg::MAX_WIDTH];
    logic [2*PB-1:0] rd_data_reg;
    logic            fwd_hit_reg;
    logic [2*PB-1:0] fwd_data_reg;

    // window stage
    logic           b_valid_reg;
    pau_pkg::pix_t  b_pixel_reg;
    logic [CB-1:0]  b_col_reg;
    logic [RB-1:0]  b_row_reg;
    logic [3:0]     b_mask_reg;
    logic           b_three_reg;
    pau_pkg::col3_t win1_reg;
    pau_pkg::col3_t win2_reg;

    // block sequencer stage
    logic [3:0]     c_mask_reg;
    pau_pkg::col3_t c_left_a_reg;
    pau_pkg::col3_t c_w1_reg;
    pau_pkg::col3_t c_cur_reg;
    pau_pkg::col3_t c_left_b_reg;
    logic [1:0]     c_tprev_reg;
    logic [1:0]     c_tlast_reg;
    logic [CB-1:0]  c_col_reg;
    logic [RB-1:0]  c_row_reg;
    logic           c_three_reg;

    // output register
    logic           out_valid_reg;
    pau_pkg::blk_t  out_blk_reg;
    logic [CB-1:0]  out_col_reg;
    logic [RB-1:0]  out_row_reg;
    logic           out_last_reg;

    logic [pau_pkg::WIDTH_BITS-1:0]  w_eff, w_last;
    logic [pau_pkg::HEIGHT_BITS-1:0] h_eff, h_last;
    logic           acc_rowend, acc_lastrow;
    logic           accept, b_go, c_free, c_emit, out_ok;
    logic [3:0]     acc_mask;
    logic [2*PB-1:0] b_rd;
    logic [2*PB-1:0] wr_data;
    pau_pkg::col3_t b_cur, b_left_a, b_left_b;
    logic [1:0]     em_sel;
    logic [3:0]     c_rest;
    pau_pkg::col3_t sel_l, sel_c, sel_r;
    logic [1:0]     sel_t, sel_m;
    logic [CB-1:0]  sel_col;
    logic [RB-1:0]  sel_row;
    pau_pkg::blk_t  nbr, blk;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pau_pkg::WIDTH_RESET;
            height_reg <= pau_pkg::HEIGHT_RESET;
            scale_reg  <= pau_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pau_pkg::CFG_WIDTH:  width_reg  <= cfg_data[pau_pkg::WIDTH_BITS-1:0];
                pau_pkg::CFG_HEIGHT: height_reg <= cfg_data[pau_pkg::HEIGHT_BITS-1:0];
                pau_pkg::CFG_SCALE:  scale_reg  <= cfg_data[pau_pkg::SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size and edge flags of the pixel at the input
    always_comb
    begin
        if (width_reg == '0)
            w_eff = pau_pkg::WIDTH_BITS'(1);
        else if (width_reg > pau_pkg::WIDTH_BITS'(pau_pkg::MAX_WIDTH))
            w_eff = pau_pkg::WIDTH_BITS'(pau_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = pau_pkg::HEIGHT_BITS'(1);
        else if (height_reg > pau_pkg::HEIGHT_BITS'(pau_pkg::MAX_HEIGHT))
            h_eff = pau_pkg::HEIGHT_BITS'(pau_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
        w_last = w_eff - pau_pkg::WIDTH_BITS'(1);
        h_last = h_eff - pau_pkg::HEIGHT_BITS'(1);
        acc_rowend  = pau_pkg::WIDTH_BITS'(col_reg) >= w_last;
        acc_lastrow = pau_pkg::HEIGHT_BITS'(row_reg) >= h_last;
        acc_mask[EM_PREV_LEFT] = (row_reg != '0) && (col_reg != '0);
        acc_mask[EM_PREV_END]  = (row_reg != '0) && acc_rowend;
        acc_mask[EM_LAST_LEFT] = acc_lastrow && (col_reg != '0);
        acc_mask[EM_LAST_END]  = acc_lastrow && acc_rowend;
    end

    // handshake and stage advance
    assign out_ok   = !out_valid_reg || !out_stall;
    assign c_emit   = (c_mask_reg != '0) && out_ok;
    assign c_free   = (c_mask_reg == '0) || (c_emit && (c_rest == '0));
    assign b_go     = b_valid_reg && c_free;
    assign in_stall = b_valid_reg && !c_free;
    assign accept   = in_valid && !in_stall;

    // pixel counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (acc_rowend)
            begin
                col_reg <= '0;
                row_reg <= acc_lastrow ? '0 : row_reg + RB'(1);
            end
            else
            begin
                col_reg <= col_reg + CB'(1);
            end
        end
    end

    // window stage: line store read data and the new column
    assign b_rd     = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data  = {b_rd[PB-1:0], b_pixel_reg};

    always_comb
    begin
        b_cur[SLOT_OLDER] = b_rd[2*PB-1:PB];
        b_cur[SLOT_NEWER] = b_rd[PB-1:0];
        b_cur[SLOT_CUR]   = b_pixel_reg;
        b_left_a = (b_col_reg >= CB'(2)) ? win2_reg : win1_reg;
        b_left_b = (b_col_reg != '0) ? win1_reg : b_cur;
    end

    // line store: read at accept, write when the pixel leaves the window stage
    always_ff @(posedge clk)
    begin
        if (b_go)
            line_mem[b_col_reg] <= wr_data;
        if (accept)
        begin
            rd_data_reg  <= line_mem[col_reg];
            fwd_data_reg <= wr_data;
        end
    end

    // window stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            win1_reg    <= '0;
            win2_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                b_valid_reg <= 1'b1;
                fwd_hit_reg <= b_go && (b_col_reg == col_reg);
            end
            else if (b_go)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_go)
            begin
                win2_reg <= win1_reg;
                win1_reg <= b_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_pixel_reg <= pixel;
            b_col_reg   <= col_reg;
            b_row_reg   <= row_reg;
            b_mask_reg  <= acc_mask;
            b_three_reg <= (scale_reg == pau_pkg::SCALE_3X);
        end
    end

    // sequencer: lowest pending emission goes first
    always_comb
    begin
        if (c_mask_reg[EM_PREV_LEFT])
            em_sel = EM_PREV_LEFT;
        else if (c_mask_reg[EM_PREV_END])
            em_sel = EM_PREV_END;
        else if (c_mask_reg[EM_LAST_LEFT])
            em_sel = EM_LAST_LEFT;
        else
            em_sel = EM_LAST_END;
        c_rest = c_mask_reg;
        c_rest[em_sel] = 1'b0;
    end

    // columns, row slots and position of the selected block
    always_comb
    begin
        sel_l   = c_left_a_reg;
        sel_c   = c_w1_reg;
        sel_r   = c_cur_reg;
        sel_t   = c_tprev_reg;
        sel_m   = SLOT_NEWER;
        sel_col = c_col_reg - CB'(1);
        sel_row = c_row_reg - RB'(1);
        case (em_sel)
            EM_PREV_LEFT: ;
            EM_PREV_END:
            begin
                sel_l   = c_left_b_reg;
                sel_c   = c_cur_reg;
                sel_col = c_col_reg;
            end
            EM_LAST_LEFT:
            begin
                sel_t   = c_tlast_reg;
                sel_m   = SLOT_CUR;
                sel_row = c_row_reg;
            end
            default:
            begin
                sel_l   = c_left_b_reg;
                sel_c   = c_cur_reg;
                sel_t   = c_tlast_reg;
                sel_m   = SLOT_CUR;
                sel_col = c_col_reg;
                sel_row = c_row_reg;
            end
        endcase
        nbr[0] = pick_slot(sel_l, sel_t);
        nbr[1] = pick_slot(sel_c, sel_t);
        nbr[2] = pick_slot(sel_r, sel_t);
        nbr[3] = pick_slot(sel_l, sel_m);
        nbr[4] = pick_slot(sel_c, sel_m);
        nbr[5] = pick_slot(sel_r, sel_m);
        nbr[6] = sel_l[SLOT_CUR];
        nbr[7] = sel_c[SLOT_CUR];
        nbr[8] = sel_r[SLOT_CUR];
    end

    pau_rules u_rules (
        .three (c_three_reg),
        .nbr   (nbr),
        .blk   (blk)
    );

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_mask_reg <= '0;
        else if (b_go)
            c_mask_reg <= b_mask_reg;
        else if (c_emit)
            c_mask_reg <= c_rest;
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            c_left_a_reg <= b_left_a;
            c_w1_reg     <= win1_reg;
            c_cur_reg    <= b_cur;
            c_left_b_reg <= b_left_b;
            c_tprev_reg  <= (b_row_reg >= RB'(2)) ? SLOT_OLDER : SLOT_NEWER;
            c_tlast_reg  <= (b_row_reg != '0) ? SLOT_NEWER : SLOT_CUR;
            c_col_reg    <= b_col_reg;
            c_row_reg    <= b_row_reg;
            c_three_reg  <= b_three_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (c_emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (c_emit)
        begin
            out_blk_reg  <= blk;
            out_col_reg  <= sel_col;
            out_row_reg  <= sel_row;
            out_last_reg <= (c_rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign block_col = out_col_reg;
    assign block_row = out_row_reg;
    assign out_0     = out_blk_reg[0];
    assign out_1     = out_blk_reg[1];
    assign out_2     = out_blk_reg[2];
    assign out_3     = out_blk_reg[3];
    assign out_4     = out_blk_reg[4];
    assign out_5     = out_blk_reg[5];
    assign out_6     = out_blk_reg[6];
    assign out_7     = out_blk_reg[7];
    assign out_8     = out_blk_reg[8];
    assign last      = out_last_reg;

    // checks
    `ASSERT_AT(a_emit_clears_one, (c_emit && !b_go) |=> ($countones(c_mask_reg) + 1 == $countones($past(c_mask_reg))), "sequencer did not retire exactly one block")
    `ASSERT_AT(a_last_empties, (c_emit && (c_rest == '0) && !b_go) |=> (c_mask_reg == '0), "sequencer not empty after last block")
    `ASSERT_AT(a_row_wrap, (accept && acc_rowend) |=> (col_reg == '0), "column count did not wrap at row end")
    `ASSERT_NEVER(a_emit_while_full, c_emit && out_valid_reg && out_stall, "output register overwritten while stalled")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench for pixel_art_upscale_2x_3x, the 2x / 3x pixel-art block upscaler
// streams raster frames, predicts every output block in-bench and checks each word
// depends on pau_pkg and the upscaler rtl only

module tb_top;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_PRINTED  = 100;
    localparam int RANDOM_ITEMS = 210;
    // index 3 holds no register, writes there must change nothing
    localparam logic [pau_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam pau_pkg::pix_t INK   = 32'hFFFF_FFFF;
    localparam pau_pkg::pix_t PAPER = 32'h0000_0000;

    // one output block as the checker sees it
    typedef struct packed {
        logic [pau_pkg::COL_BITS-1:0] col;
        logic [pau_pkg::ROW_BITS-1:0] row;
        pau_pkg::blk_t                px;
        logic                         last;
    } block_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [pau_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [pau_pkg::CFG_BITS-1:0]     cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    pau_pkg::pix_t                    pixel;
    logic                             out_valid;
    logic                             out_stall;
    logic [pau_pkg::COL_BITS-1:0]     block_col;
    logic [pau_pkg::ROW_BITS-1:0]     block_row;
    pau_pkg::pix_t                    out_0, out_1, out_2, out_3, out_4;
    pau_pkg::pix_t                    out_5, out_6, out_7, out_8;
    logic                             last;

    // upscaler state as predicted by the bench
    logic [pau_pkg::WIDTH_BITS-1:0]  width_reg  = pau_pkg::WIDTH_RESET;
    logic [pau_pkg::HEIGHT_BITS-1:0] height_reg = pau_pkg::HEIGHT_RESET;
    logic [pau_pkg::SCALE_BITS-1:0]  scale_reg  = pau_pkg::SCALE_RESET;
    pau_pkg::pix_t  row_older [pau_pkg::MAX_WIDTH] = '{default: '0};
    pau_pkg::pix_t  row_newer [pau_pkg::MAX_WIDTH] = '{default: '0};
    pau_pkg::col3_t win_prev  = '0;
    pau_pkg::col3_t win_prev2 = '0;
    int unsigned    col_pos   = 0;
    int unsigned    row_pos   = 0;

    block_t pending_blocks [$];
    int     error_count  = 0;
    int     cycle_count  = 0;
    int     random_sent  = 0;
    bit     calm         = 1'b0;

    pixel_art_upscale_2x_3x u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .block_col (block_col),
        .block_row (block_row),
        .out_0     (out_0),
        .out_1     (out_1),
        .out_2     (out_2),
        .out_3     (out_3),
        .out_4     (out_4),
        .out_5     (out_5),
        .out_6     (out_6),
        .out_7     (out_7),
        .out_8     (out_8),
        .last      (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // effective frame size after the zero and saturation rules
    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > pau_pkg::MAX_WIDTH)
            return pau_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > pau_pkg::MAX_HEIGHT)
            return pau_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    // pixel-art rules on one 3x3 neighborhood picked from three window columns
    function automatic block_t scale_block(pau_pkg::col3_t lft, pau_pkg::col3_t mid,
                                           pau_pkg::col3_t rgt, int st, int sm, int sb,
                                           int unsigned cx, int unsigned cy, bit three);
        block_t        blk;
        pau_pkg::pix_t pa, pb, pc, pd, pe, pf, pg, ph, pi;
        bit            tl, tr, bl, br;
        pa = lft[st]; pb = mid[st]; pc = rgt[st];
        pd = lft[sm]; pe = mid[sm]; pf = rgt[sm];
        pg = lft[sb]; ph = mid[sb]; pi = rgt[sb];
        tl = pd == pb && pd != ph && pb != pf;
        tr = pb == pf && pb != pd && pf != ph;
        bl = ph == pd && ph != pf && pd != pb;
        br = pf == ph && pf != pb && ph != pd;
        blk = '0;
        blk.col = pau_pkg::COL_BITS'(cx);
        blk.row = pau_pkg::ROW_BITS'(cy);
        if (!three)
        begin
            blk.px[0] = tl ? pb : pe;
            blk.px[1] = tr ? pf : pe;
            blk.px[3] = bl ? pd : pe;
            blk.px[4] = br ? ph : pe;
        end
        else
        begin
            blk.px[0] = tl ? pd : pe;
            blk.px[1] = ((tl && pe != pc) || (tr && pe != pa)) ? pb : pe;
            blk.px[2] = tr ? pf : pe;
            blk.px[3] = ((bl && pe != pa) || (tl && pe != pg)) ? pd : pe;
            blk.px[4] = pe;
            blk.px[5] = ((tr && pe != pi) || (br && pe != pc)) ? pf : pe;
            blk.px[6] = bl ? pd : pe;
            blk.px[7] = ((br && pe != pg) || (bl && pe != pi)) ? ph : pe;
            blk.px[8] = br ? pf : pe;
        end
        return blk;
    endfunction

    // advance the predicted state by one source pixel and queue the blocks it closes
    function automatic void predict_pixel(pau_pkg::pix_t p);
        int unsigned    w, h, x, y, idx;
        int             slot, n, k;
        bit             three, row_end, last_row;
        pau_pkg::col3_t cur, w1, w2;
        block_t         made [4];
        w = active_width();
        h = active_height();
        x = col_pos;
        y = row_pos;
        three = scale_reg == pau_pkg::SCALE_3X;
        idx = x < pau_pkg::MAX_WIDTH ? x : pau_pkg::MAX_WIDTH - 1;
        cur[0] = row_older[idx];
        cur[1] = row_newer[idx];
        cur[2] = p;
        w1 = win_prev;
        w2 = win_prev2;
        row_end = x >= w - 1;
        last_row = y >= h - 1;
        n = 0;

        // blocks of the previous row
        if (y >= 1)
        begin
            slot = y >= 2 ? 0 : 1;
            if (x >= 1)
            begin
                made[n] = scale_block(x >= 2 ? w2 : w1, w1, cur, slot, 1, 2,
                                      x - 1, y - 1, three);
                n++;
            end
            if (row_end)
            begin
                made[n] = scale_block(x >= 1 ? w1 : cur, cur, cur, slot, 1, 2,
                                      x, y - 1, three);
                n++;
            end
        end

        // last row flushes its own blocks, bottom clamped to the centre row
        if (last_row)
        begin
            slot = y >= 1 ? 1 : 2;
            if (x >= 1)
            begin
                made[n] = scale_block(x >= 2 ? w2 : w1, w1, cur, slot, 2, 2,
                                      x - 1, y, three);
                n++;
            end
            if (row_end)
            begin
                made[n] = scale_block(x >= 1 ? w1 : cur, cur, cur, slot, 2, 2,
                                      x, y, three);
                n++;
            end
        end

        for (k = 0; k < n; k++)
        begin
            made[k].last = k == n - 1;
            pending_blocks.push_back(made[k]);
        end

        // shift window and line stores
        win_prev2 = w1;
        win_prev = cur;
        row_older[idx] = row_newer[idx];
        row_newer[idx] = p;
        if (row_end)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : (y + 1) & 12'hFFF;
        end
        else
            col_pos = (x + 1) & 11'h7FF;
    endfunction

    task automatic report_mismatch(string what, block_t at_blk, logic [31:0] want,
                                   logic [31:0] got);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t: %s mismatch at block col %0d row %0d: expected %h, got %h",
                     $time, what, at_blk.col, at_blk.row, want, got);
    endtask

    // register write through the cfg port, only while the block is idle
    task automatic set_register(logic [pau_pkg::CFG_IDX_BITS-1:0] index,
                                logic [pau_pkg::CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        unique case (index)
            pau_pkg::CFG_WIDTH:  width_reg  = value[pau_pkg::WIDTH_BITS-1:0];
            pau_pkg::CFG_HEIGHT: height_reg = value;
            pau_pkg::CFG_SCALE:  scale_reg  = value[pau_pkg::SCALE_BITS-1:0];
            default:             ;
        endcase
    endtask

    // hold the source until every predicted block is out, then let the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // send one source word, at times with a random gap before it
    task automatic send_pixel(pau_pkg::pix_t p);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 11);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pixel    <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pixel(p);
    endtask

    // one full frame at the current size; colors 0 means unrestricted pixels
    task automatic send_frame(int colors);
        pau_pkg::pix_t palette [4];
        int            total, k;
        for (k = 0; k < 4; k++)
            palette[k] = $urandom;
        total = active_width() * active_height();
        for (k = 0; k < total; k++)
        begin
            if (colors == 0)
                send_pixel($urandom);
            else
                send_pixel(palette[$urandom_range(0, colors - 1)]);
            if (!calm && $urandom_range(0, 79) == 0)
                wait_drained();
        end
    endtask

    // start at the reset size, then shrink width and height inside the frame
    task automatic test_mid_frame_narrowing();
        int k;
        for (k = 0; k < 5; k++)
            send_pixel($urandom_range(0, 1) ? INK : PAPER);
        wait_drained();
        set_register(pau_pkg::CFG_WIDTH, 13'd3);
        // column 5 is already past the new row end and closes row zero
        send_pixel(INK);
        for (k = 0; k < 6; k++)
            send_pixel($urandom_range(0, 1) ? INK : PAPER);
        wait_drained();
        set_register(CFG_UNUSED, 13'h1FFF);
        // row 3 is past the new last row and flushes the frame
        set_register(pau_pkg::CFG_HEIGHT, 13'd2);
        for (k = 0; k < 3; k++)
            send_pixel($urandom_range(0, 1) ? INK : PAPER);
        wait_drained();
    endtask

    // zero sizes, scale codes 0 and 1, and a 3x3 corner pattern in 3x mode
    task automatic test_tiny_frames();
        pau_pkg::pix_t corner [9];
        int            k;
        corner = '{INK, INK, PAPER, INK, PAPER, PAPER, PAPER, PAPER, PAPER};
        set_register(pau_pkg::CFG_WIDTH, 13'd0);
        set_register(pau_pkg::CFG_HEIGHT, 13'd0);
        set_register(pau_pkg::CFG_SCALE, 13'd0);
        send_pixel(PAPER);
        send_pixel(INK);
        wait_drained();
        set_register(pau_pkg::CFG_SCALE, 13'd1);
        send_pixel(32'h8000_0001);
        wait_drained();
        set_register(pau_pkg::CFG_WIDTH, 13'd3);
        set_register(pau_pkg::CFG_HEIGHT, 13'd3);
        set_register(pau_pkg::CFG_SCALE, 13'(pau_pkg::SCALE_3X));
        for (k = 0; k < 9; k++)
            send_pixel(corner[k]);
        wait_drained();
        // the same pattern reversed, in 2x mode
        set_register(pau_pkg::CFG_SCALE, 13'(pau_pkg::SCALE_RESET));
        for (k = 0; k < 9; k++)
            send_pixel(corner[8 - k]);
        wait_drained();
    endtask

    // random small frames with few or unrestricted colors, random sizes and scale codes
    task automatic test_random_frames();
        int w, h;
        while (random_sent < RANDOM_ITEMS)
        begin
            calm = $urandom_range(0, 3) == 0;
            w = $urandom_range(0, 7) == 0 ? $urandom_range(13, 24) : $urandom_range(0, 12);
            h = $urandom_range(0, 6);
            set_register(pau_pkg::CFG_WIDTH, {1'($urandom_range(0, 1)), 12'(w)});
            set_register(pau_pkg::CFG_HEIGHT, 13'(h));
            set_register(pau_pkg::CFG_SCALE, {11'($urandom), 2'($urandom_range(0, 3))});
            send_frame($urandom_range(0, 3));
            random_sent += active_width() * active_height();
            wait_drained();
        end
        calm = 1'b0;
    endtask

    // saturated width and height, then a closing frame, with no idling on either side
    task automatic test_largest_frames();
        int k;
        calm = 1'b1;
        set_register(pau_pkg::CFG_WIDTH, 13'h0FFF);
        set_register(pau_pkg::CFG_HEIGHT, 13'h1FFF);
        set_register(pau_pkg::CFG_SCALE, 13'(pau_pkg::SCALE_3X));
        // top row of a tall frame gives no blocks
        for (k = 0; k < 6; k++)
            send_pixel($urandom_range(0, 1) ? INK : PAPER);
        wait_drained();
        // top row becomes the last row, each pixel closes one block
        set_register(pau_pkg::CFG_HEIGHT, 13'd1);
        for (k = 0; k < 8; k++)
            send_pixel($urandom_range(0, 1) ? INK : PAPER);
        wait_drained();
        // column 14 is the new row end and ends the frame
        set_register(pau_pkg::CFG_WIDTH, 13'd15);
        send_pixel(INK);
        wait_drained();
        // one column with saturated height, each pixel after the first closes the row above
        set_register(pau_pkg::CFG_WIDTH, 13'd1);
        set_register(pau_pkg::CFG_HEIGHT, 13'h1FFF);
        set_register(pau_pkg::CFG_SCALE, 13'(pau_pkg::SCALE_RESET));
        for (k = 0; k < 12; k++)
            send_pixel($urandom_range(0, 1) ? INK : PAPER);
        wait_drained();
        // row 12 is past the new last row and flushes the frame
        set_register(pau_pkg::CFG_HEIGHT, 13'd4);
        send_pixel(PAPER);
        wait_drained();
        // closing frame streamed back to back
        set_register(pau_pkg::CFG_WIDTH, 13'd9);
        set_register(pau_pkg::CFG_HEIGHT, 13'd5);
        set_register(pau_pkg::CFG_SCALE, 13'(pau_pkg::SCALE_3X));
        send_frame(2);
        wait_drained();
    endtask

    // main sequence
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = pau_pkg::CFG_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_mid_frame_narrowing();
        test_tiny_frames();
        test_random_frames();
        test_largest_frames();

        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_blocks.size() == 0)
            $display("pixel_art_upscale_2x_3x verification clean");
        else
            $display("pixel_art_upscale_2x_3x verification failed");
        $finish;
    end

    // output stall in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm || $urandom_range(0, 4) != 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end
        end
    end

    // compare each accepted block word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        block_t seen, want;
        int     k;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.col  = block_col;
            seen.row  = block_row;
            seen.px   = {out_8, out_7, out_6, out_5, out_4, out_3, out_2, out_1, out_0};
            seen.last = last;
            if (pending_blocks.size() == 0)
                report_mismatch("unexpected word", seen, 32'd0, 32'd1);
            else
            begin
                want = pending_blocks.pop_front();
                if (seen.col !== want.col)
                    report_mismatch("block_col", want, 32'(want.col), 32'(seen.col));
                if (seen.row !== want.row)
                    report_mismatch("block_row", want, 32'(want.row), 32'(seen.row));
                for (k = 0; k < 9; k++)
                    if (seen.px[k] !== want.px[k])
                        report_mismatch($sformatf("out_%0d", k), want, want.px[k], seen.px[k]);
                if (seen.last !== want.last)
                    report_mismatch("last", want, 32'(want.last), 32'(seen.last));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("pixel_art_upscale_2x_3x verification failed");
            $finish;
        end
    end

endmodule
